// File: hw/rtl/rvic_pkg.sv
// Package for the RV64I integer core: widths, opcodes, decode types and helpers.
// Used by the decode and execute modules and the top level; depends on nothing.
package rvic_pkg;

	localparam int XLEN = 64;
	localparam int DefRegCount = 32;
	localparam logic [63:0] BootReset = 64'h0000_0000_8000_0000;
	localparam logic [63:0] StackReset = 64'h0000_0000_8800_0000;
	localparam int QueueDepth = 2;

	// Configuration register indexes.
	localparam logic CFG_BOOT = 1'b0;
	localparam logic CFG_STACK = 1'b1;

	// Major opcodes.
	localparam logic [6:0] OP_REG = 7'h33;
	localparam logic [6:0] OP_REGW = 7'h3b;
	localparam logic [6:0] OP_IMM = 7'h13;
	localparam logic [6:0] OP_IMMW = 7'h1b;
	localparam logic [6:0] OP_LUI = 7'h37;
	localparam logic [6:0] OP_AUIPC = 7'h17;
	localparam logic [6:0] OP_JAL = 7'h6f;
	localparam logic [6:0] OP_JALR = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LOAD = 7'h03;
	localparam logic [6:0] OP_STORE = 7'h23;

	localparam logic [6:0] F7_ZERO = 7'h00;
	localparam logic [6:0] F7_ALT = 7'h20;

	// Operation classes chosen by the decoder.
	typedef enum logic [3:0] {
		ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU, ALU_XOR, ALU_SRL, ALU_SRA,
		ALU_OR, ALU_AND, ALU_PASSB
	} alu_op_t;

	typedef enum logic [2:0] {
		CLS_ALU, CLS_BRANCH, CLS_JAL, CLS_JALR, CLS_LOAD, CLS_STORE, CLS_ILLEGAL,
		CLS_LRET
	} cls_t;

	// Decoded item passed from the front to the back.
	typedef struct packed {
		cls_t cls;
		alu_op_t alu_op;
		logic word_op;
		logic a_is_pc;
		logic b_is_imm;
		logic [2:0] funct3;
		logic [4:0] rd;
		logic [4:0] rs1;
		logic [4:0] rs2;
		logic [63:0] imm;
		logic [63:0] load_data;
	} dec_t;

	function automatic logic [63:0] size_mask(input logic [1:0] sz);
		case (sz)
			2'd0: size_mask = 64'h0000_0000_0000_00ff;
			2'd1: size_mask = 64'h0000_0000_0000_ffff;
			2'd2: size_mask = 64'h0000_0000_ffff_ffff;
			default: size_mask = '1;
		endcase
	endfunction

endpackage

// File: hw/rtl/rvic_decode.sv
// Front end of the integer core: classifies each input item and builds its immediate.
// Depends on rvic_pkg.
module rvic_decode (
	input logic kind,
	input logic [31:0] instr_word,
	input logic [63:0] load_data,
	output rvic_pkg::dec_t dec
);
	import rvic_pkg::*;

	logic [6:0] op;
	logic [2:0] f3;
	logic [6:0] f7;
	logic [63:0] immi, imms, immb, immj, immu;

	assign op = instr_word[6:0];
	assign f3 = instr_word[14:12];
	assign f7 = instr_word[31:25];
	assign immi = {{52{instr_word[31]}}, instr_word[31:20]};
	assign imms = {{52{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
	assign immb = {{51{instr_word[31]}}, instr_word[31], instr_word[7], instr_word[30:25],
		instr_word[11:8], 1'b0};
	assign immj = {{43{instr_word[31]}}, instr_word[31], instr_word[19:12], instr_word[20],
		instr_word[30:21], 1'b0};
	assign immu = {{32{instr_word[31]}}, instr_word[31:12], 12'h000};

	// Mask-and-match decode of the instruction word.
	always_comb begin
		dec = '0;
		dec.cls = CLS_ALU;
		dec.alu_op = ALU_ADD;
		dec.funct3 = f3;
		dec.rd = instr_word[11:7];
		dec.rs1 = instr_word[19:15];
		dec.rs2 = instr_word[24:20];
		dec.load_data = load_data;
		if (kind) begin
			dec.cls = CLS_LRET;
		end else begin
			case (op)
				OP_REG: begin
					if (f7 == F7_ZERO) begin
						case (f3)
							3'd0: dec.alu_op = ALU_ADD;
							3'd1: dec.alu_op = ALU_SLL;
							3'd2: dec.alu_op = ALU_SLT;
							3'd3: dec.alu_op = ALU_SLTU;
							3'd4: dec.alu_op = ALU_XOR;
							3'd5: dec.alu_op = ALU_SRL;
							3'd6: dec.alu_op = ALU_OR;
							default: dec.alu_op = ALU_AND;
						endcase
					end else if (f7 == F7_ALT && f3 == 3'd0) begin
						dec.alu_op = ALU_SUB;
					end else if (f7 == F7_ALT && f3 == 3'd5) begin
						dec.alu_op = ALU_SRA;
					end else begin
						dec.cls = CLS_ILLEGAL;
					end
				end
				OP_REGW: begin
					dec.word_op = 1'b1;
					if (f7 == F7_ZERO && f3 == 3'd0) dec.alu_op = ALU_ADD;
					else if (f7 == F7_ZERO && f3 == 3'd1) dec.alu_op = ALU_SLL;
					else if (f7 == F7_ZERO && f3 == 3'd5) dec.alu_op = ALU_SRL;
					else if (f7 == F7_ALT && f3 == 3'd0) dec.alu_op = ALU_SUB;
					else if (f7 == F7_ALT && f3 == 3'd5) dec.alu_op = ALU_SRA;
					else dec.cls = CLS_ILLEGAL;
				end
				OP_IMM: begin
					dec.b_is_imm = 1'b1;
					dec.imm = immi;
					case (f3)
						3'd0: dec.alu_op = ALU_ADD;
						3'd2: dec.alu_op = ALU_SLT;
						3'd3: dec.alu_op = ALU_SLTU;
						3'd4: dec.alu_op = ALU_XOR;
						3'd6: dec.alu_op = ALU_OR;
						3'd7: dec.alu_op = ALU_AND;
						3'd1: begin
							dec.alu_op = ALU_SLL;
							if (instr_word[31:26] != 6'h00) dec.cls = CLS_ILLEGAL;
						end
						default: begin
							if (instr_word[31:26] == 6'h00) dec.alu_op = ALU_SRL;
							else if (instr_word[31:26] == 6'h10) dec.alu_op = ALU_SRA;
							else dec.cls = CLS_ILLEGAL;
						end
					endcase
				end
				OP_IMMW: begin
					dec.b_is_imm = 1'b1;
					dec.word_op = 1'b1;
					dec.imm = immi;
					if (f3 == 3'd0) dec.alu_op = ALU_ADD;
					else if (f3 == 3'd1 && f7 == F7_ZERO) dec.alu_op = ALU_SLL;
					else if (f3 == 3'd5 && f7 == F7_ZERO) dec.alu_op = ALU_SRL;
					else if (f3 == 3'd5 && f7 == F7_ALT) dec.alu_op = ALU_SRA;
					else dec.cls = CLS_ILLEGAL;
				end
				OP_LUI: begin
					dec.alu_op = ALU_PASSB;
					dec.b_is_imm = 1'b1;
					dec.imm = immu;
				end
				OP_AUIPC: begin
					dec.a_is_pc = 1'b1;
					dec.b_is_imm = 1'b1;
					dec.imm = immu;
				end
				OP_JAL: begin
					dec.cls = CLS_JAL;
					dec.imm = immj;
				end
				OP_JALR: begin
					dec.cls = (f3 == 3'd0) ? CLS_JALR : CLS_ILLEGAL;
					dec.imm = immi;
				end
				OP_BRANCH: begin
					dec.cls = (f3 == 3'd2 || f3 == 3'd3) ? CLS_ILLEGAL : CLS_BRANCH;
					dec.imm = immb;
				end
				OP_LOAD: begin
					dec.cls = (f3 == 3'd7) ? CLS_ILLEGAL : CLS_LOAD;
					dec.imm = immi;
				end
				OP_STORE: begin
					dec.cls = f3[2] ? CLS_ILLEGAL : CLS_STORE;
					dec.imm = imms;
				end
				default: dec.cls = CLS_ILLEGAL;
			endcase
		end
	end

endmodule

// File: hw/rtl/rvic_queue.sv
// Small register queue between the front and back ends, and on the result side.
// Depends on nothing but its parameters.
module rvic_queue #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [Width-1:0] wdata,
	output logic full,
	input logic pop,
	output logic [Width-1:0] rdata,
	output logic empty
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

	logic [Width-1:0] slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PtrW:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == (PtrW+1)'(Depth));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = slot_q[rd_ptr_q];

	// Pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= wdata;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> count_q == (PtrW+1)'(Depth) || $past(do_pop))
		else $error("queue count changed while full without a transfer out");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on a transfer in");
	a_ptr_eq: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> wr_ptr_q == rd_ptr_q)
		else $error("empty queue with unequal pointers");
`endif

endmodule

// File: hw/rtl/rvic_execute.sv
// Back end of the integer core: register file, PC, ALU, branch and load tracking.
// Depends on rvic_pkg.
module rvic_execute #(
	parameter int RegCount = rvic_pkg::DefRegCount
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [63:0] cfg_wdata,
	input logic go,
	input rvic_pkg::dec_t dec,
	output logic [63:0] fetch_address,
	output logic wb_valid,
	output logic [4:0] wb_index,
	output logic [63:0] wb_value,
	output logic mem_valid,
	output logic mem_write,
	output logic [63:0] mem_addr,
	output logic [1:0] mem_size,
	output logic [63:0] mem_wdata,
	output logic illegal
);
	import rvic_pkg::*;

	logic [63:0] regs_q [RegCount];
	logic [63:0] pc_q;
	logic ld_pend_q, ld_signed_q;
	logic [4:0] ld_dest_q;
	logic [1:0] ld_size_q;

	logic [63:0] ra, rb, opa, opb, res, res64, ldv, next;
	logic [5:0] sh;
	logic [31:0] aw;
	logic lt_s, lt_u, taken, wr, wr_ok;
	logic [4:0] wdst;

	// Register reads; x0 and registers beyond the count read as zero.
	always_comb begin
		ra = '0;
		rb = '0;
		for (int i = 1; i < RegCount; i++) begin
			if (dec.rs1 == 5'(i)) ra = regs_q[i];
			if (dec.rs2 == 5'(i)) rb = regs_q[i];
		end
	end

	assign opa = dec.a_is_pc ? pc_q : ra;
	assign opb = dec.b_is_imm ? dec.imm : rb;
	assign sh = dec.word_op ? {1'b0, opb[4:0]} : opb[5:0];
	assign aw = opa[31:0];
	assign lt_s = $signed(opa) < $signed(opb);
	assign lt_u = opa < opb;

	// ALU.
	always_comb begin
		case (dec.alu_op)
			ALU_ADD: res64 = opa + opb;
			ALU_SUB: res64 = opa - opb;
			ALU_SLL: res64 = opa << sh;
			ALU_SLT: res64 = {63'd0, lt_s};
			ALU_SLTU: res64 = {63'd0, lt_u};
			ALU_XOR: res64 = opa ^ opb;
			ALU_SRL: res64 = dec.word_op ? {32'd0, aw >> sh[4:0]} : opa >> sh;
			ALU_SRA: res64 = dec.word_op ? {32'd0, 32'($signed(aw) >>> sh[4:0])}
				: 64'($signed(opa) >>> sh);
			ALU_OR: res64 = opa | opb;
			ALU_AND: res64 = opa & opb;
			ALU_PASSB: res64 = opb;
			default: res64 = '0;
		endcase
		res = dec.word_op ? {{32{res64[31]}}, res64[31:0]} : res64;
	end

	// Branch condition on the two register values.
	always_comb begin
		case (dec.funct3)
			3'd0: taken = ra == rb;
			3'd1: taken = ra != rb;
			3'd4: taken = $signed(ra) < $signed(rb);
			3'd5: taken = !($signed(ra) < $signed(rb));
			3'd6: taken = ra < rb;
			3'd7: taken = !(ra < rb);
			default: taken = 1'b0;
		endcase
	end

	// Load return data, masked and extended.
	always_comb begin
		ldv = dec.load_data & size_mask(ld_size_q);
		if (ld_signed_q) begin
			case (ld_size_q)
				2'd0: ldv = {{56{ldv[7]}}, ldv[7:0]};
				2'd1: ldv = {{48{ldv[15]}}, ldv[15:0]};
				2'd2: ldv = {{32{ldv[31]}}, ldv[31:0]};
				default: ldv = ldv;
			endcase
		end
	end

	// Result of one item.
	always_comb begin
		next = pc_q + 64'd4;
		wr = 1'b0;
		wdst = dec.rd;
		wb_value = '0;
		mem_valid = 1'b0;
		mem_write = 1'b0;
		mem_addr = '0;
		mem_size = '0;
		mem_wdata = '0;
		illegal = 1'b0;
		case (dec.cls)
			CLS_ALU: begin
				wr = 1'b1;
				wb_value = res;
			end
			CLS_JAL: begin
				wr = 1'b1;
				wb_value = pc_q + 64'd4;
				next = pc_q + dec.imm;
			end
			CLS_JALR: begin
				wr = 1'b1;
				wb_value = pc_q + 64'd4;
				next = (ra + dec.imm) & ~64'd1;
			end
			CLS_BRANCH: if (taken) next = pc_q + dec.imm;
			CLS_LOAD: begin
				mem_valid = 1'b1;
				mem_addr = ra + dec.imm;
				mem_size = dec.funct3[1:0];
			end
			CLS_STORE: begin
				mem_valid = 1'b1;
				mem_write = 1'b1;
				mem_addr = ra + dec.imm;
				mem_size = dec.funct3[1:0];
				mem_wdata = rb & size_mask(dec.funct3[1:0]);
			end
			CLS_LRET: begin
				next = pc_q;
				wr = ld_pend_q;
				wdst = ld_dest_q;
				wb_value = ldv;
			end
			default: illegal = 1'b1;
		endcase
		wr_ok = wr && wdst != 5'd0 && 32'(wdst) < RegCount;
		wb_valid = wr_ok;
		wb_index = wr_ok ? wdst : 5'd0;
		if (!wr_ok) wb_value = '0;
		fetch_address = next;
	end

	// Architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RegCount; i++) regs_q[i] <= (i == 2) ? StackReset : '0;
			pc_q <= BootReset;
			ld_pend_q <= 1'b0;
			ld_dest_q <= '0;
			ld_size_q <= '0;
			ld_signed_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_BOOT) pc_q <= cfg_wdata;
			else if (RegCount > 2) regs_q[2] <= cfg_wdata;
		end else if (go) begin
			pc_q <= next;
			for (int i = 1; i < RegCount; i++) begin
				if (wr_ok && wdst == 5'(i)) regs_q[i] <= wb_value;
			end
			if (dec.cls == CLS_LRET) ld_pend_q <= 1'b0;
			if (dec.cls == CLS_LOAD) begin
				ld_pend_q <= 1'b1;
				ld_dest_q <= dec.rd;
				ld_size_q <= dec.funct3[1:0];
				ld_signed_q <= !dec.funct3[2];
			end
		end
	end

`ifndef SYNTHESIS
	a_x0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		regs_q[0] == '0)
		else $error("register x0 became nonzero");
	a_wb_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!wb_valid |-> wb_index == 5'd0 && wb_value == '0)
		else $error("writeback fields set without a writeback");
	a_ld_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !cfg_we && dec.cls == CLS_LRET) |=> !ld_pend_q)
		else $error("load still pending after its return");
`endif

endmodule

// File: hw/rtl/rv64i_integer_core.sv
// Top level of the RV64I integer core: decode front, item queue, execute back, result queue.
// Depends on rvic_pkg, rvic_decode, rvic_queue and rvic_execute.
//
// The core executes one RV64I instruction, or one returning load, per item and sustains one
// item per clock while the result queue has room. An accepted item is decoded on the way in
// and written into a two-entry queue at the accepting edge. From the head of that queue the
// execute stage reads the register file, runs the ALU and writes back, limited by that single
// register-read/ALU/write loop, and places the result in a two-entry result queue, whose head
// drives the ports.
// Configuration writes load the PC or x2 immediately and are meant for when the core is idle.
module rv64i_integer_core #(
	parameter int RegCount = rvic_pkg::DefRegCount
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [63:0] cfg_wdata,
	input logic push,
	output logic full,
	input logic kind,
	input logic [31:0] instr_word,
	input logic [63:0] load_data,
	output logic empty,
	input logic pop,
	output logic [63:0] fetch_address,
	output logic wb_valid,
	output logic [4:0] wb_index,
	output logic [63:0] wb_value,
	output logic mem_valid,
	output logic mem_write,
	output logic [63:0] mem_addr,
	output logic [1:0] mem_size,
	output logic [63:0] mem_wdata,
	output logic illegal
);
	import rvic_pkg::*;

	localparam int ResW = 64 + 1 + 5 + 64 + 1 + 1 + 64 + 2 + 64 + 1;

	dec_t dec_s1, dec_q;
	logic iq_empty, rq_full, go;
	logic [ResW-1:0] res_w, res_r;
	logic [63:0] x_fa, x_wbv, x_ma, x_md;
	logic x_wv, x_mv, x_mw, x_il;
	logic [4:0] x_wi;
	logic [1:0] x_ms;

	// Front end classification.
	rvic_decode u_dec (
		.kind(kind), .instr_word(instr_word), .load_data(load_data), .dec(dec_s1)
	);

	// Queue of decoded items.
	rvic_queue #(.Width($bits(dec_t)), .Depth(QueueDepth)) u_iq (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(dec_s1), .full(full),
		.pop(go), .rdata(dec_q), .empty(iq_empty)
	);

	assign go = !iq_empty && !rq_full;

	// Back end execution.
	rvic_execute #(.RegCount(RegCount)) u_exe (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .go(go), .dec(dec_q),
		.fetch_address(x_fa), .wb_valid(x_wv), .wb_index(x_wi), .wb_value(x_wbv),
		.mem_valid(x_mv), .mem_write(x_mw), .mem_addr(x_ma), .mem_size(x_ms),
		.mem_wdata(x_md), .illegal(x_il)
	);

	assign res_w = {x_fa, x_wv, x_wi, x_wbv, x_mv, x_mw, x_ma, x_ms, x_md, x_il};

	// Result queue toward the consumer.
	rvic_queue #(.Width(ResW), .Depth(QueueDepth)) u_rq (
		.clk(clk), .arst_n(arst_n), .push(go), .wdata(res_w), .full(rq_full),
		.pop(pop), .rdata(res_r), .empty(empty)
	);

	assign {fetch_address, wb_valid, wb_index, wb_value, mem_valid, mem_write, mem_addr,
		mem_size, mem_wdata, illegal} = res_r;

`ifndef SYNTHESIS
	a_go_cond: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !iq_empty && !rq_full)
		else $error("execute fired without an item or room");
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(wb_valid && mem_valid && mem_write))
		else $error("store result also carries a writeback");
	a_ill_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && illegal) |-> !wb_valid && !mem_valid)
		else $error("illegal result carries side effects");
`endif

endmodule

// File: test/rv64i_integer_core_test.sv
// Self-checking testbench for the RV64I integer core: directed rows, then random programs.
// Depends on rvic_pkg and rv64i_integer_core; results are predicted by an internal model.
module rv64i_integer_core_test;
	import rvic_pkg::*;

	// funct3 codes for ALU, branch and memory forms.
	localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
	localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
	localparam logic [2:0] F3_LB = 3'd0, F3_LD = 3'd3, F3_LWU = 3'd6, F3_LBAD = 3'd7;
	localparam logic [1:0] SZ_DOUBLE = 2'd3;
	localparam logic KIND_INSTR = 1'b0, KIND_LRET = 1'b1;
	localparam logic [6:0] OP_SYSTEM = 7'h73, OP_FENCE = 7'h0f;

	typedef struct {
		logic [63:0] fetch_address;
		logic wb_valid;
		logic [4:0] wb_index;
		logic [63:0] wb_value;
		logic mem_valid;
		logic mem_write;
		logic [63:0] mem_addr;
		logic [1:0] mem_size;
		logic [63:0] mem_wdata;
		logic illegal;
	} retire_t;

	typedef struct {
		logic kind;
		logic [31:0] word;
		logic [63:0] data;
		logic typed;
		retire_t result;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_BOOT;
	logic [63:0] cfg_wdata = '0;
	logic push = 1'b0;
	logic full;
	logic kind = KIND_INSTR;
	logic [31:0] instr_word = '0;
	logic [63:0] load_data = '0;
	logic empty;
	logic pop = 1'b0;
	logic [63:0] fetch_address;
	logic wb_valid;
	logic [4:0] wb_index;
	logic [63:0] wb_value;
	logic mem_valid;
	logic mem_write;
	logic [63:0] mem_addr;
	logic [1:0] mem_size;
	logic [63:0] mem_wdata;
	logic illegal;

	// Architectural state of the core as the testbench sees it.
	logic [63:0] arch_regs [32];
	logic [63:0] arch_pc;
	logic pend_load;
	logic [4:0] pend_dest;
	logic [1:0] pend_size;
	logic pend_signed;

	retire_t retire_queue[$];
	row_t rows[$];
	int fails = 0;
	int burst_left = 0;
	int pop_rate = 100;
	int pop_cycle = 0;

	rv64i_integer_core i_dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 400000);
		$display("rv64i_integer_core test failed");
		$finish;
	end

	function automatic logic [63:0] sext32(input logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic logic [31:0] enc(input logic [6:0] hi, input logic [4:0] rs2,
		input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd,
		input logic [6:0] op);
		return {hi, rs2, rs1, f3, rd, op};
	endfunction

	function automatic void write_reg(inout retire_t r, input logic [4:0] idx,
		input logic [63:0] v);
		if (idx != 5'd0) begin
			arch_regs[idx] = v;
			r.wb_valid = 1'b1;
			r.wb_index = idx;
			r.wb_value = v;
		end
	endfunction

	// Executes one item against the state and returns the retired result.
	function automatic retire_t retire_item(input logic k, input logic [31:0] w,
		input logic [63:0] ld);
		retire_t r;
		logic [6:0] op, f7;
		logic [2:0] f3;
		logic [4:0] rd;
		logic [63:0] a, b, nxt, res, immi, imms, immb, immj, immu, d;
		logic wr, bad, taken;
		r = '{default: '0};
		if (k == KIND_LRET) begin
			if (pend_load) begin
				d = ld & size_mask(pend_size);
				if (pend_signed && pend_size != SZ_DOUBLE)
					d = (pend_size == 2'd0) ? {{56{d[7]}}, d[7:0]} :
						(pend_size == 2'd1) ? {{48{d[15]}}, d[15:0]} : sext32(d);
				pend_load = 1'b0;
				write_reg(r, pend_dest, d);
			end
			r.fetch_address = arch_pc;
			return r;
		end
		op = w[6:0];
		f3 = w[14:12];
		f7 = w[31:25];
		rd = w[11:7];
		a = (w[19:15] == 5'd0) ? 64'd0 : arch_regs[w[19:15]];
		b = (w[24:20] == 5'd0) ? 64'd0 : arch_regs[w[24:20]];
		nxt = arch_pc + 64'd4;
		immi = {{52{w[31]}}, w[31:20]};
		imms = {{52{w[31]}}, w[31:25], w[11:7]};
		immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
		immu = {{32{w[31]}}, w[31:12], 12'b0};
		res = '0;
		wr = 1'b0;
		bad = 1'b0;
		taken = 1'b0;
		case (op)
			OP_REG: begin
				wr = 1'b1;
				if (f7 == F7_ZERO) begin
					case (f3)
						F3_ADD: res = a + b;
						F3_SLL: res = a << b[5:0];
						F3_SLT: res = {63'd0, $signed(a) < $signed(b)};
						F3_SLTU: res = {63'd0, a < b};
						F3_XOR: res = a ^ b;
						F3_SR: res = a >> b[5:0];
						F3_OR: res = a | b;
						default: res = a & b;
					endcase
				end else if (f7 == F7_ALT && f3 == F3_ADD) res = a - b;
				else if (f7 == F7_ALT && f3 == F3_SR) res = $signed(a) >>> b[5:0];
				else bad = 1'b1;
			end
			OP_REGW: begin
				wr = 1'b1;
				if (f7 == F7_ZERO && f3 == F3_ADD) res = sext32(a + b);
				else if (f7 == F7_ZERO && f3 == F3_SLL) res = sext32(a << b[4:0]);
				else if (f7 == F7_ZERO && f3 == F3_SR) res = sext32({32'd0, a[31:0]} >> b[4:0]);
				else if (f7 == F7_ALT && f3 == F3_ADD) res = sext32(a - b);
				else if (f7 == F7_ALT && f3 == F3_SR) res = sext32($signed(sext32(a)) >>> b[4:0]);
				else bad = 1'b1;
			end
			OP_IMM: begin
				wr = 1'b1;
				case (f3)
					F3_ADD: res = a + immi;
					F3_SLT: res = {63'd0, $signed(a) < $signed(immi)};
					F3_SLTU: res = {63'd0, a < immi};
					F3_XOR: res = a ^ immi;
					F3_OR: res = a | immi;
					F3_AND: res = a & immi;
					F3_SLL: begin
						if (w[31:26] == 6'h00) res = a << w[25:20];
						else bad = 1'b1;
					end
					default: begin
						if (w[31:26] == 6'h00) res = a >> w[25:20];
						else if (w[31:26] == 6'h10) res = $signed(a) >>> w[25:20];
						else bad = 1'b1;
					end
				endcase
			end
			OP_IMMW: begin
				wr = 1'b1;
				if (f3 == F3_ADD) res = sext32(a + immi);
				else if (f3 == F3_SLL && f7 == F7_ZERO) res = sext32(a << w[24:20]);
				else if (f3 == F3_SR && f7 == F7_ZERO)
					res = sext32({32'd0, a[31:0]} >> w[24:20]);
				else if (f3 == F3_SR && f7 == F7_ALT)
					res = sext32($signed(sext32(a)) >>> w[24:20]);
				else bad = 1'b1;
			end
			OP_LUI: begin
				wr = 1'b1;
				res = immu;
			end
			OP_AUIPC: begin
				wr = 1'b1;
				res = arch_pc + immu;
			end
			OP_JAL: begin
				wr = 1'b1;
				res = arch_pc + 64'd4;
				nxt = arch_pc + immj;
			end
			OP_JALR: begin
				if (f3 == 3'd0) begin
					wr = 1'b1;
					res = arch_pc + 64'd4;
					nxt = (a + immi) & ~64'd1;
				end else bad = 1'b1;
			end
			OP_BRANCH: begin
				case (f3)
					F3_BEQ: taken = (a == b);
					F3_BNE: taken = (a != b);
					F3_BLT: taken = ($signed(a) < $signed(b));
					F3_BGE: taken = ($signed(a) >= $signed(b));
					F3_BLTU: taken = (a < b);
					F3_BGEU: taken = (a >= b);
					default: bad = 1'b1;
				endcase
				if (taken) nxt = arch_pc + immb;
			end
			OP_LOAD: begin
				if (f3 == F3_LBAD) bad = 1'b1;
				else begin
					pend_load = 1'b1;
					pend_dest = rd;
					pend_size = f3[1:0];
					pend_signed = !f3[2];
					r.mem_valid = 1'b1;
					r.mem_addr = a + immi;
					r.mem_size = f3[1:0];
				end
			end
			OP_STORE: begin
				if (f3[2]) bad = 1'b1;
				else begin
					r.mem_valid = 1'b1;
					r.mem_write = 1'b1;
					r.mem_addr = a + imms;
					r.mem_size = f3[1:0];
					r.mem_wdata = b & size_mask(f3[1:0]);
				end
			end
			default: bad = 1'b1;
		endcase
		if (bad) begin
			nxt = arch_pc + 64'd4;
			r.illegal = 1'b1;
		end else if (wr) begin
			write_reg(r, rd, res);
		end
		arch_pc = nxt;
		r.fetch_address = nxt;
		return r;
	endfunction

	function automatic retire_t typed_result(input logic [63:0] fa, input logic wv,
		input logic [4:0] idx, input logic [63:0] val, input logic ill);
		retire_t r;
		r = '{default: '0};
		r.fetch_address = fa;
		r.wb_valid = wv;
		r.wb_index = idx;
		r.wb_value = val;
		r.illegal = ill;
		return r;
	endfunction

	task automatic add_row(input logic k, input logic [31:0] w, input logic [63:0] d);
		rows.push_back('{kind: k, word: w, data: d, typed: 1'b0, result: '{default: '0}});
	endtask

	task automatic add_typed(input logic k, input logic [31:0] w, input logic [63:0] d,
		input retire_t r);
		rows.push_back('{kind: k, word: w, data: d, typed: 1'b1, result: r});
	endtask

	// Drives one item until its transfer and records the expected result.
	task automatic send_item(input row_t row);
		retire_t r;
		push <= 1'b1;
		kind <= row.kind;
		instr_word <= row.word;
		load_data <= row.data;
		do @(posedge clk); while (full);
		r = retire_item(row.kind, row.word, row.data);
		if (row.typed) r = row.result;
		retire_queue.push_back(r);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) :
				$urandom_range(0, 12);
		end
	endtask

	// Waits for the core to drain, then writes one configuration register.
	task automatic write_config(input logic idx, input logic [63:0] v);
		push <= 1'b0;
		while (retire_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BOOT) arch_pc = v;
		else arch_regs[2] = v;
	endtask

	// Builds a random item: mostly well-formed instructions, load returns mostly after loads.
	function automatic row_t random_row(input logic after_load);
		row_t row;
		logic [6:0] op, hi;
		logic [2:0] f3;
		int pick;
		row = '{kind: KIND_INSTR, word: $urandom, data: {$urandom, $urandom},
			typed: 1'b0, result: '{default: '0}};
		if (after_load ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 19) == 0)) begin
			row.kind = KIND_LRET;
			return row;
		end
		if ($urandom_range(0, 19) == 0) return row;
		pick = $urandom_range(0, 10);
		case (pick)
			0: op = OP_REG;
			1: op = OP_REGW;
			2: op = OP_IMM;
			3: op = OP_IMMW;
			4: op = OP_LUI;
			5: op = OP_AUIPC;
			6: op = OP_JAL;
			7: op = OP_JALR;
			8: op = OP_BRANCH;
			9: op = OP_LOAD;
			default: op = OP_STORE;
		endcase
		f3 = 3'($urandom_range(0, 7));
		hi = 7'($urandom);
		if (op == OP_REG || op == OP_REGW || op == OP_IMMW ||
			(op == OP_IMM && (f3 == F3_SLL || f3 == F3_SR))) begin
			if ($urandom_range(0, 9) != 0) begin
				hi = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
				if (op == OP_IMM) hi[0] = 1'($urandom_range(0, 1));
			end
		end
		if (op == OP_JALR && $urandom_range(0, 7) != 0) f3 = 3'd0;
		if (op == OP_STORE && $urandom_range(0, 7) != 0) f3[2] = 1'b0;
		row.word = enc(hi, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), f3,
			5'($urandom_range(0, 31)), op);
		return row;
	endfunction

	task automatic random_phase(input int count);
		row_t row;
		logic last_load;
		last_load = 1'b0;
		repeat (count) begin
			row = random_row(last_load);
			last_load = (row.kind == KIND_INSTR && row.word[6:0] == OP_LOAD);
			send_item(row);
		end
	endtask

	// Result side: check each transfer against the oldest expectation.
	always @(posedge clk) begin
		retire_t e;
		if (arst_n && pop && !empty) begin
			if (retire_queue.size() == 0) begin
				$error("result transfer with no expectation waiting");
				fails++;
			end else begin
				e = retire_queue.pop_front();
				if (fetch_address !== e.fetch_address) begin
					$error("fetch_address exp %h got %h", e.fetch_address, fetch_address);
					fails++;
				end
				if (wb_valid !== e.wb_valid) begin
					$error("wb_valid exp %h got %h", e.wb_valid, wb_valid);
					fails++;
				end
				if (wb_index !== e.wb_index) begin
					$error("wb_index exp %h got %h", e.wb_index, wb_index);
					fails++;
				end
				if (wb_value !== e.wb_value) begin
					$error("wb_value exp %h got %h", e.wb_value, wb_value);
					fails++;
				end
				if (mem_valid !== e.mem_valid) begin
					$error("mem_valid exp %h got %h", e.mem_valid, mem_valid);
					fails++;
				end
				if (mem_write !== e.mem_write) begin
					$error("mem_write exp %h got %h", e.mem_write, mem_write);
					fails++;
				end
				if (mem_addr !== e.mem_addr) begin
					$error("mem_addr exp %h got %h", e.mem_addr, mem_addr);
					fails++;
				end
				if (mem_size !== e.mem_size) begin
					$error("mem_size exp %h got %h", e.mem_size, mem_size);
					fails++;
				end
				if (mem_wdata !== e.mem_wdata) begin
					$error("mem_wdata exp %h got %h", e.mem_wdata, mem_wdata);
					fails++;
				end
				if (illegal !== e.illegal) begin
					$error("illegal exp %h got %h", e.illegal, illegal);
					fails++;
				end
			end
		end
		// Stall pattern: the pop rate is redrawn periodically from 100, 70 or 25 percent.
		pop_cycle++;
		if (pop_cycle % 64 == 0) pop_rate = ($urandom_range(0, 2) == 0) ? 100 :
			($urandom_range(0, 1) ? 70 : 25);
		pop <= ($urandom_range(0, 99) < pop_rate);
	end

	// Main sequence: reset, directed rows, then random phases under several settings.
	initial begin
		foreach (arch_regs[i]) arch_regs[i] = '0;
		arch_regs[2] = StackReset;
		arch_pc = BootReset;
		pend_load = 1'b0;
		pend_dest = '0;
		pend_size = '0;
		pend_signed = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset: an illegal word, a stray load return, then a copy of x2 into x1 and a write to x0.
		add_typed(KIND_INSTR, 32'h0000_0000, '0,
			typed_result(BootReset + 64'd4, 1'b0, 5'd0, '0, 1'b1));
		add_typed(KIND_LRET, 32'hffff_ffff, '1,
			typed_result(BootReset + 64'd4, 1'b0, 5'd0, '0, 1'b0));
		add_typed(KIND_INSTR, enc(7'h00, 5'd0, 5'd2, F3_ADD, 5'd1, OP_IMM), '0,
			typed_result(BootReset + 64'd8, 1'b1, 5'd1, StackReset, 1'b0));
		add_typed(KIND_INSTR, enc(7'h7f, 5'h1f, 5'd0, F3_ADD, 5'd0, OP_IMM), '0,
			typed_result(BootReset + 64'd12, 1'b0, 5'd0, '0, 1'b0));
		add_row(KIND_INSTR, enc(7'h7f, 5'h1f, 5'd0, F3_ADD, 5'd3, OP_IMM), '0);
		add_row(KIND_INSTR, enc(7'h40, 5'd0, 5'd0, 3'd0, 5'd4, OP_LUI), '0);
		add_row(KIND_INSTR, enc(F7_ZERO, 5'd3, 5'd3, F3_SLL, 5'd5, OP_REG), '0);
		add_row(KIND_INSTR, enc(F7_ALT, 5'd3, 5'd4, F3_SR, 5'd6, OP_REG), '0);
		add_row(KIND_INSTR, enc(F7_ALT, 5'd4, 5'd0, F3_ADD, 5'd7, OP_REG), '0);
		add_row(KIND_INSTR, enc(F7_ZERO, 5'd3, 5'd4, F3_SLT, 5'd8, OP_REG), '0);
		add_row(KIND_INSTR, enc(F7_ZERO, 5'd3, 5'd4, F3_SLTU, 5'd9, OP_REG), '0);
		add_row(KIND_INSTR, enc(F7_ZERO, 5'd4, 5'd4, F3_ADD, 5'd10, OP_REGW), '0);
		add_row(KIND_INSTR, enc(F7_ZERO, 5'h1f, 5'd3, F3_SR, 5'd11, OP_IMMW), '0);
		add_row(KIND_INSTR, enc(F7_ALT, 5'd1, 5'd4, F3_SR, 5'd12, OP_IMMW), '0);
		// W-immediate shift with bit 25 set is illegal; 64-bit SRAI by 63 is not.
		add_row(KIND_INSTR, enc(7'h01, 5'd0, 5'd3, F3_SLL, 5'd13, OP_IMMW), '0);
		add_row(KIND_INSTR, enc(7'h21, 5'h1f, 5'd4, F3_SR, 5'd13, OP_IMM), '0);
		// JALR to an even target keeps bit 1; JAL with an offset of -2.
		add_row(KIND_INSTR, enc(7'h7f, 5'h1f, 5'd3, 3'd0, 5'd1, OP_JALR), '0);
		add_row(KIND_INSTR, enc(7'h7f, 5'h1f, 5'h1f, 3'd7, 5'd0, OP_JAL), '0);
		add_row(KIND_INSTR, enc(7'h00, 5'd0, 5'd0, F3_BEQ, 5'd8, OP_BRANCH), '0);
		add_row(KIND_INSTR, enc(7'h7f, 5'd3, 5'd4, F3_BLT, 5'h1f, OP_BRANCH), '0);
		add_row(KIND_INSTR, enc(7'h00, 5'd4, 5'd3, 3'd2, 5'd0, OP_BRANCH), '0);
		// Loads of both signs and three sizes, and their returns.
		add_row(KIND_INSTR, enc(7'h00, 5'd0, 5'd2, F3_LD, 5'd14, OP_LOAD), '0);
		add_row(KIND_LRET, '0, '1);
		add_row(KIND_INSTR, enc(7'h7f, 5'h1f, 5'd0, F3_LB, 5'd15, OP_LOAD), '0);
		add_row(KIND_LRET, '0, 64'h1234_5678_9abc_de80);
		add_row(KIND_INSTR, enc(7'h00, 5'd0, 5'd4, F3_LWU, 5'd16, OP_LOAD), '1);
		add_row(KIND_LRET, '0, '1);
		add_row(KIND_INSTR, enc(7'h00, 5'd0, 5'd4, F3_LBAD, 5'd16, OP_LOAD), '0);
		add_row(KIND_INSTR, enc(7'h7f, 5'd3, 5'd2, 3'd0, 5'h1f, OP_STORE), '0);
		add_row(KIND_INSTR, enc(7'h00, 5'd3, 5'd2, 3'd4, 5'd0, OP_STORE), '0);
		add_row(KIND_INSTR, enc(7'h00, 5'd0, 5'd0, 3'd0, 5'd0, OP_SYSTEM), '0);
		add_row(KIND_INSTR, enc(7'h00, 5'd0, 5'd0, 3'd0, 5'd0, OP_FENCE), '0);
		foreach (rows[i]) send_item(rows[i]);

		write_config(CFG_BOOT, 64'd0);
		write_config(CFG_STACK, '1);
		random_phase(300);
		write_config(CFG_BOOT, 64'hffff_ffff_ffff_fffc);
		write_config(CFG_STACK, 64'd0);
		random_phase(300);
		write_config(CFG_BOOT, {$urandom, $urandom});
		write_config(CFG_STACK, {$urandom, $urandom});
		random_phase(320);

		push <= 1'b0;
		while (retire_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0 && retire_queue.size() == 0) begin
			$display("rv64i_integer_core test passed");
		end else begin
			$display("rv64i_integer_core test failed");
		end
		$finish;
	end

endmodule
